// File: hdl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// types and constants of the constrained shortest path unit
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int NODES   = 256;
  localparam int NODE_W  = $clog2(NODES);
  localparam int CNT_W   = $clog2(NODES + 1);
  localparam int EDGE_AW = 2 * NODE_W;
  localparam int VAL_W   = 32;
  localparam int HOP_W   = 8;
  localparam int CIDX_W  = 3;

  localparam logic [VAL_W-1:0] ONE_HOP = 32'h0001_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;
  localparam logic [HOP_W-1:0] HOP_MAX = '1;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] STAT_FOUND   = 2'd0;
  localparam logic [1:0] STAT_UNREACH = 2'd1;
  localparam logic [1:0] STAT_LIMIT   = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_NODE_COUNT     = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_MINIMIZE_HOPS  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_HOP_LIMIT_ON   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_HOP_LIMIT      = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_VALUE_LIMIT_ON = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_VALUE_LIMIT    = 3'd5;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       src_node;
    logic [7:0]       dst_node;
    logic [VAL_W-1:0] edge_distance;
    logic             both_ways;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] path_distance;
    logic [HOP_W-1:0] path_hops;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE2,
    S_INIT,
    S_SCAN,
    S_RELAX,
    S_FIN
  } state_t;

endpackage

// File: hdl/constrained_shortest_path_unit.sv
// ----------------------------------------------------------------------------
// constrained_shortest_path_unit
// matrix dijkstra over a stored adjacency matrix with hop and distance limits
// ----------------------------------------------------------------------------
// edge write: one entry, a second (S_EDGE2) with the reverse edge; clear: all NODES*NODES entries
// query: alternating node scans (S_SCAN) and matrix row passes (S_RELAX) over the
// n nodes in use, one entry per cycle, until the destination settles or is unreachable
// reset: synchronous; a clearing pass over all NODES*NODES entries of the edge
// memory runs after reset with in_ready low, config writes taken throughout
module constrained_shortest_path_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  csp_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output csp_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [csp_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [csp_pkg::VAL_W-1:0]      cfg_data
);

  logic [csp_pkg::VAL_W-1:0] edge_mem [csp_pkg::NODES*csp_pkg::NODES];
  logic [csp_pkg::VAL_W-1:0] wt_mem [csp_pkg::NODES];
  logic [csp_pkg::VAL_W-1:0] ds_mem [csp_pkg::NODES];
  logic [csp_pkg::HOP_W-1:0] hp_mem [csp_pkg::NODES];

  csp_pkg::state_t state_r, state_nxt;

  logic [csp_pkg::CNT_W-1:0]   node_count_r;
  logic                        min_hops_r, hlim_on_r, vlim_on_r;
  logic [csp_pkg::HOP_W-1:0]   hlim_r;
  logic [csp_pkg::VAL_W-1:0]   vlim_r;

  logic [csp_pkg::NODES-1:0]   reached_r, settled_r, reached_nxt, settled_nxt;
  logic [csp_pkg::EDGE_AW-1:0] clr_r, clr_nxt;
  logic [csp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        pend_r, pend_nxt;
  logic [csp_pkg::NODE_W-1:0]  pidx_r, pidx_nxt;
  logic [csp_pkg::NODE_W-1:0]  q_src_r, q_src_nxt, q_dst_r, q_dst_nxt;
  logic [csp_pkg::VAL_W-1:0]   q_dist_r, q_dist_nxt;
  logic                        found_r, found_nxt;
  logic [csp_pkg::NODE_W-1:0]  best_r, best_nxt;
  logic [csp_pkg::VAL_W-1:0]   best_w_r, best_w_nxt, best_d_r, best_d_nxt;
  logic [csp_pkg::HOP_W-1:0]   best_h_r, best_h_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  csp_pkg::out_item_t          out_r, out_nxt;

  logic [csp_pkg::VAL_W-1:0]   rd_w, rd_d, rd_e;
  logic [csp_pkg::HOP_W-1:0]   rd_h;

  logic                        e_we;
  logic [csp_pkg::EDGE_AW-1:0] e_waddr;
  logic [csp_pkg::VAL_W-1:0]   e_wdata;
  logic                        n_we;
  logic [csp_pkg::NODE_W-1:0]  n_waddr;
  logic [csp_pkg::VAL_W-1:0]   n_wdata_w, n_wdata_d;
  logic [csp_pkg::HOP_W-1:0]   n_wdata_h;
  logic                        flag_clr, set_reach, set_settle;
  logic [csp_pkg::NODE_W-1:0]  reach_idx, settle_idx;

  logic [csp_pkg::CNT_W-1:0]   n_used;
  logic [csp_pkg::VAL_W:0]     sum_w, sum_d;
  logic [csp_pkg::VAL_W-1:0]   step_w, new_w, new_d;
  logic [csp_pkg::HOP_W-1:0]   new_h;
  logic                        elig, better, upd;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == csp_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (node_count_r < csp_pkg::CNT_W'(2)) n_used = csp_pkg::CNT_W'(2);
    else if (node_count_r > csp_pkg::CNT_W'(csp_pkg::NODES))
      n_used = csp_pkg::CNT_W'(csp_pkg::NODES);
    else n_used = node_count_r;
  end

  // scan candidate and relax arithmetic
  always_comb begin
    elig = reached_r[pidx_r] && !settled_r[pidx_r] &&
           !(vlim_on_r && rd_d > vlim_r) && !(hlim_on_r && rd_h > hlim_r);
    better = elig && (!found_r || rd_w < best_w_r);
    step_w = min_hops_r ? csp_pkg::ONE_HOP : rd_e;
    sum_w  = {1'b0, best_w_r} + {1'b0, step_w};
    sum_d  = {1'b0, best_d_r} + {1'b0, rd_e};
    new_w  = sum_w[csp_pkg::VAL_W] ? csp_pkg::VAL_MAX : sum_w[csp_pkg::VAL_W-1:0];
    new_d  = sum_d[csp_pkg::VAL_W] ? csp_pkg::VAL_MAX : sum_d[csp_pkg::VAL_W-1:0];
    new_h  = (best_h_r == csp_pkg::HOP_MAX) ? csp_pkg::HOP_MAX
                                            : best_h_r + csp_pkg::HOP_W'(1);
    upd = (rd_e != '0) && !settled_r[pidx_r] && (!reached_r[pidx_r] || rd_w > new_w);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    q_src_nxt     = q_src_r;
    q_dst_nxt     = q_dst_r;
    q_dist_nxt    = q_dist_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_w_nxt    = best_w_r;
    best_d_nxt    = best_d_r;
    best_h_nxt    = best_h_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    e_we          = 1'b0;
    e_waddr       = clr_r;
    e_wdata       = '0;
    n_we          = 1'b0;
    n_waddr       = q_src_r;
    n_wdata_w     = '0;
    n_wdata_d     = '0;
    n_wdata_h     = '0;
    flag_clr      = 1'b0;
    set_reach     = 1'b0;
    set_settle    = 1'b0;
    reach_idx     = q_src_r;
    settle_idx    = best_r;
    unique case (state_r)
      csp_pkg::S_CLEAR: begin
        e_we    = 1'b1;
        clr_nxt = clr_r + csp_pkg::EDGE_AW'(1);
        if (clr_r == '1) state_nxt = csp_pkg::S_IDLE;
      end
      csp_pkg::S_IDLE: begin
        if (in_valid) begin
          q_src_nxt  = in_data.src_node;
          q_dst_nxt  = in_data.dst_node;
          q_dist_nxt = in_data.edge_distance;
          priority if (in_data.action == csp_pkg::ACT_WRITE) begin
            e_we    = 1'b1;
            e_waddr = {in_data.src_node, in_data.dst_node};
            e_wdata = in_data.edge_distance;
            if (in_data.both_ways) state_nxt = csp_pkg::S_EDGE2;
          end else if (in_data.action == csp_pkg::ACT_QUERY) begin
            state_nxt = csp_pkg::S_INIT;
          end else if (in_data.action == csp_pkg::ACT_CLEAR) begin
            clr_nxt   = '0;
            state_nxt = csp_pkg::S_CLEAR;
          end
        end
      end
      csp_pkg::S_EDGE2: begin
        e_we      = 1'b1;
        e_waddr   = {q_dst_r, q_src_r};
        e_wdata   = q_dist_r;
        state_nxt = csp_pkg::S_IDLE;
      end
      csp_pkg::S_INIT: begin
        flag_clr = 1'b1;
        if ({1'b0, q_src_r} >= n_used || {1'b0, q_dst_r} >= n_used) begin
          status_nxt = csp_pkg::STAT_UNREACH;
          state_nxt  = csp_pkg::S_FIN;
        end else begin
          n_we      = 1'b1;
          set_reach = 1'b1;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = csp_pkg::S_SCAN;
        end
      end
      csp_pkg::S_SCAN: begin
        if (cnt_r < n_used) begin
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[csp_pkg::NODE_W-1:0];
          cnt_nxt  = cnt_r + csp_pkg::CNT_W'(1);
        end
        if (pend_r && better) begin
          found_nxt  = 1'b1;
          best_nxt   = pidx_r;
          best_w_nxt = rd_w;
          best_d_nxt = rd_d;
          best_h_nxt = rd_h;
        end
        if (cnt_r == n_used && !pend_r) begin
          if (!found_r) begin
            status_nxt = csp_pkg::STAT_UNREACH;
            state_nxt  = csp_pkg::S_FIN;
          end else begin
            set_settle = 1'b1;
            cnt_nxt    = '0;
            if (best_r == q_dst_r) begin
              if (vlim_on_r && vlim_r != '0 && best_w_r > vlim_r)
                status_nxt = csp_pkg::STAT_LIMIT;
              else status_nxt = csp_pkg::STAT_FOUND;
              state_nxt = csp_pkg::S_FIN;
            end else begin
              state_nxt = csp_pkg::S_RELAX;
            end
          end
        end
      end
      csp_pkg::S_RELAX: begin
        if (cnt_r < n_used) begin
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[csp_pkg::NODE_W-1:0];
          cnt_nxt  = cnt_r + csp_pkg::CNT_W'(1);
        end
        if (pend_r && upd) begin
          n_we      = 1'b1;
          n_waddr   = pidx_r;
          n_wdata_w = new_w;
          n_wdata_d = new_d;
          n_wdata_h = new_h;
          set_reach = 1'b1;
          reach_idx = pidx_r;
        end
        if (cnt_r == n_used && !pend_r) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = csp_pkg::S_SCAN;
        end
      end
      csp_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = status_r;
          if (status_r == csp_pkg::STAT_FOUND) begin
            out_nxt.path_distance = best_d_r;
            out_nxt.path_hops     = best_h_r;
          end else begin
            out_nxt.path_distance = '0;
            out_nxt.path_hops     = '0;
          end
          state_nxt = csp_pkg::S_IDLE;
        end
      end
      default: state_nxt = csp_pkg::S_IDLE;
    endcase
  end

  // reached and settled flags
  always_comb begin
    reached_nxt = flag_clr ? '0 : reached_r;
    settled_nxt = flag_clr ? '0 : settled_r;
    if (set_reach) reached_nxt[reach_idx] = 1'b1;
    if (set_settle) settled_nxt[settle_idx] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csp_pkg::S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      reached_r   <= '0;
      settled_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      reached_r   <= reached_nxt;
      settled_r   <= settled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r   <= pidx_nxt;
    q_src_r  <= q_src_nxt;
    q_dst_r  <= q_dst_nxt;
    q_dist_r <= q_dist_nxt;
    best_r   <= best_nxt;
    best_w_r <= best_w_nxt;
    best_d_r <= best_d_nxt;
    best_h_r <= best_h_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= csp_pkg::CNT_W'(csp_pkg::NODES);
      min_hops_r   <= 1'b0;
      hlim_on_r    <= 1'b0;
      hlim_r       <= csp_pkg::HOP_MAX;
      vlim_on_r    <= 1'b0;
      vlim_r       <= csp_pkg::VAL_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        csp_pkg::CFG_NODE_COUNT:     node_count_r <= cfg_data[csp_pkg::CNT_W-1:0];
        csp_pkg::CFG_MINIMIZE_HOPS:  min_hops_r   <= cfg_data[0];
        csp_pkg::CFG_HOP_LIMIT_ON:   hlim_on_r    <= cfg_data[0];
        csp_pkg::CFG_HOP_LIMIT:      hlim_r       <= cfg_data[csp_pkg::HOP_W-1:0];
        csp_pkg::CFG_VALUE_LIMIT_ON: vlim_on_r    <= cfg_data[0];
        csp_pkg::CFG_VALUE_LIMIT:    vlim_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // edge matrix
  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_waddr] <= e_wdata;
    rd_e <= edge_mem[{best_r, cnt_r[csp_pkg::NODE_W-1:0]}];
  end

  // node records
  always_ff @(posedge clk) begin
    if (n_we) begin
      wt_mem[n_waddr] <= n_wdata_w;
      ds_mem[n_waddr] <= n_wdata_d;
      hp_mem[n_waddr] <= n_wdata_h;
    end
    rd_w <= wt_mem[cnt_r[csp_pkg::NODE_W-1:0]];
    rd_d <= ds_mem[cnt_r[csp_pkg::NODE_W-1:0]];
    rd_h <= hp_mem[cnt_r[csp_pkg::NODE_W-1:0]];
  end

endmodule
